// File: rtl/core/wfba_pkg.sv
// Shared types and constants for the worst-fit block allocator.
// No dependencies; the scan unit, top level, checker and bench refer to it by scoped names.
package wfba_pkg;

    localparam int MAX_BLOCKS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    localparam int SIZE_W  = 16;
    localparam int INDEX_W = 4;
    localparam int REQ_W   = 16;
    localparam int SUM_W   = 20;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_REQUEST = 2'd1,
        OP_CLEAR   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_GRANT = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2,
        ST_DONE  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DECIDE,
        S_FIN
    } state_t;

    typedef struct packed {
        logic start;
        logic valid;
    } scan_ctl_t;

endpackage

// File: rtl/core/wfba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wfba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/wfba_scan.sv
// Shared compare unit: tracks the largest free fitting block over a table scan.
// Depends on wfba_pkg for the scan control struct.
module wfba_scan #(
    parameter int SW = 16,
    parameter int IW = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  wfba_pkg::scan_ctl_t ctl,
    input  logic                taken_bit,
    input  logic [SW-1:0]       blk_size,
    input  logic [IW-1:0]       blk_idx,
    input  logic [SW-1:0]       req_size,
    output logic                found,
    output logic [SW-1:0]       best,
    output logic [IW-1:0]       pick
);

    logic          found_reg;
    logic          found_next;
    logic [SW-1:0] best_reg;
    logic [SW-1:0] best_next;
    logic [IW-1:0] pick_reg;
    logic [IW-1:0] pick_next;
    logic          hit;

    always_comb
    begin
        hit = ctl.valid && !taken_bit && (blk_size >= req_size)
            && (!found_reg || (blk_size >= best_reg));
        found_next = found_reg;
        best_next  = best_reg;
        pick_next  = pick_reg;
        if (ctl.start)
        begin
            found_next = 1'b0;
        end
        else if (hit)
        begin
            found_next = 1'b1;
            best_next  = blk_size;
            pick_next  = blk_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        pick_reg <= pick_next;
    end

    assign found = found_reg;
    assign best  = best_reg;
    assign pick  = pick_reg;

endmodule

// File: rtl/core/worst_fit_block_allocator_top.sv
// Top level of the worst-fit block allocator: sequencer, totals, taken marks.
// Depends on wfba_pkg, wfba_ram and wfba_scan.
//
// Input channel: in_valid/in_stall with operation and size. in_stall is high
// while an item is being worked on, so one item is in flight at a time.
// Output channel: out_valid/out_stall with status, block_index, leftover,
// request_number, used_total and capacity_total; one beat per input beat.
// A load, a clear or an unused code passes from the execute state to the finish
// state and into the output register; the next item is taken back in idle.
// A request reads every stored block once through the block-size RAM and the
// shared compare unit (scan state, then decide state) before the finish state;
// a request on an empty table skips the scan and is refused with no fit.
// The output register parts the channels: a new item is taken while a result
// still waits; if the receiver stalls, the next finished result holds inside
// until the output register frees up, and in_stall stays high meanwhile.
// Reset empties the table, clears taken marks, counters and totals and drops
// any pending output beat; no clearing pass is needed.
module worst_fit_block_allocator_top #(
    parameter int MAX_BLOCKS = wfba_pkg::MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = wfba_pkg::SIZE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    operation,
    input  logic [wfba_pkg::SIZE_W-1:0]   size,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [wfba_pkg::INDEX_W-1:0]  block_index,
    output logic [wfba_pkg::SIZE_W-1:0]   leftover,
    output logic [wfba_pkg::REQ_W-1:0]    request_number,
    output logic [wfba_pkg::SUM_W-1:0]    used_total,
    output logic [wfba_pkg::SUM_W-1:0]    capacity_total
);

    localparam int SW = (SIZE_BITS < wfba_pkg::SIZE_W) ? SIZE_BITS : wfba_pkg::SIZE_W;
    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int XW = wfba_pkg::SUM_W + 1;
    localparam int IXW = IW + wfba_pkg::INDEX_W;

    wfba_pkg::state_t state_reg;
    wfba_pkg::state_t state_next;

    logic [1:0]            op_reg;
    logic [1:0]            op_next;
    logic [SW-1:0]         size_reg;
    logic [SW-1:0]         size_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [wfba_pkg::REQ_W-1:0] req_reg;
    logic [wfba_pkg::REQ_W-1:0] req_next;
    logic [wfba_pkg::SUM_W-1:0] used_reg;
    logic [wfba_pkg::SUM_W-1:0] used_next;
    logic [wfba_pkg::SUM_W-1:0] cap_reg;
    logic [wfba_pkg::SUM_W-1:0] cap_next;
    logic [MAX_BLOCKS-1:0] taken_reg;
    logic [MAX_BLOCKS-1:0] taken_next;
    logic [CW-1:0]         issue_reg;
    logic [CW-1:0]         issue_next;
    logic                  cmp_valid_reg;
    logic                  cmp_valid_next;
    logic [IW-1:0]         cmp_idx_reg;
    logic [IW-1:0]         cmp_idx_next;

    logic [1:0]            res_status_reg;
    logic [1:0]            res_status_next;
    logic [IW-1:0]         res_index_reg;
    logic [IW-1:0]         res_index_next;
    logic [SW-1:0]         res_left_reg;
    logic [SW-1:0]         res_left_next;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [1:0]                 out_status_reg;
    logic [1:0]                 out_status_next;
    logic [wfba_pkg::INDEX_W-1:0] out_index_reg;
    logic [wfba_pkg::INDEX_W-1:0] out_index_next;
    logic [wfba_pkg::SIZE_W-1:0]  out_left_reg;
    logic [wfba_pkg::SIZE_W-1:0]  out_left_next;
    logic [wfba_pkg::REQ_W-1:0]   out_req_reg;
    logic [wfba_pkg::REQ_W-1:0]   out_req_next;
    logic [wfba_pkg::SUM_W-1:0]   out_used_reg;
    logic [wfba_pkg::SUM_W-1:0]   out_used_next;
    logic [wfba_pkg::SUM_W-1:0]   out_cap_reg;
    logic [wfba_pkg::SUM_W-1:0]   out_cap_next;

    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    logic [IW-1:0]       ram_raddr;
    logic [SW-1:0]       ram_rdata;
    wfba_pkg::scan_ctl_t scan_ctl;
    logic                scan_found;
    logic [SW-1:0]       scan_best;
    logic [IW-1:0]       scan_pick;
    logic [XW-1:0]       sum_add;
    logic [XW-1:0]       sum_base;
    logic [IXW-1:0]      index_wide;
    logic                out_free;

    wfba_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_BLOCKS)
    ) u_sizes (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (size_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    wfba_scan #(
        .SW (SW),
        .IW (IW)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .taken_bit (taken_reg[cmp_idx_reg]),
        .blk_size  (ram_rdata),
        .blk_idx   (cmp_idx_reg),
        .req_size  (size_reg),
        .found     (scan_found),
        .best      (scan_best),
        .pick      (scan_pick)
    );

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        size_next       = size_reg;
        count_next      = count_reg;
        req_next        = req_reg;
        used_next       = used_reg;
        cap_next        = cap_reg;
        taken_next      = taken_reg;
        issue_next      = issue_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_left_next   = res_left_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_left_next   = out_left_reg;
        out_req_next    = out_req_reg;
        out_used_next   = out_used_reg;
        out_cap_next    = out_cap_reg;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[IW-1:0];
        ram_raddr       = issue_reg[IW-1:0];
        scan_ctl.start  = 1'b0;
        scan_ctl.valid  = 1'b0;
        sum_base        = {1'b0, cap_reg};
        sum_add         = sum_base + XW'(size_reg);
        index_wide      = {{wfba_pkg::INDEX_W{1'b0}}, res_index_reg};
        out_free        = !out_valid_reg || !out_stall;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            wfba_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = operation;
                    size_next  = size[SW-1:0];
                    state_next = wfba_pkg::S_EXEC;
                end
            end
            wfba_pkg::S_EXEC:
            begin
                res_status_next = wfba_pkg::ST_DONE;
                res_index_next  = '0;
                res_left_next   = '0;
                state_next      = wfba_pkg::S_FIN;
                case (op_reg)
                    wfba_pkg::OP_LOAD:
                    begin
                        if (count_reg < CW'(MAX_BLOCKS))
                        begin
                            ram_we                      = 1'b1;
                            taken_next[count_reg[IW-1:0]] = 1'b0;
                            res_index_next              = count_reg[IW-1:0];
                            count_next                  = count_reg + CW'(1);
                            sum_base                    = {1'b0, cap_reg};
                            sum_add                     = sum_base + XW'(size_reg);
                            cap_next = sum_add[XW-1] ? '1 : sum_add[XW-2:0];
                        end
                        else
                        begin
                            res_status_next = wfba_pkg::ST_FULL;
                        end
                    end
                    wfba_pkg::OP_REQUEST:
                    begin
                        if (req_reg != '1)
                        begin
                            req_next = req_reg + wfba_pkg::REQ_W'(1);
                        end
                        if (count_reg == '0)
                        begin
                            res_status_next = wfba_pkg::ST_NOFIT;
                        end
                        else
                        begin
                            issue_next     = '0;
                            scan_ctl.start = 1'b1;
                            state_next     = wfba_pkg::S_SCAN;
                        end
                    end
                    wfba_pkg::OP_CLEAR:
                    begin
                        taken_next = '0;
                        count_next = '0;
                        used_next  = '0;
                        cap_next   = '0;
                    end
                    default:
                    begin
                        res_status_next = wfba_pkg::ST_DONE;
                    end
                endcase
            end
            wfba_pkg::S_SCAN:
            begin
                if (issue_reg < count_reg)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_reg[IW-1:0];
                    issue_next     = issue_reg + CW'(1);
                end
                scan_ctl.valid = cmp_valid_reg;
                if (cmp_valid_reg && ((CW'(cmp_idx_reg) + CW'(1)) == count_reg))
                begin
                    state_next = wfba_pkg::S_DECIDE;
                end
            end
            wfba_pkg::S_DECIDE:
            begin
                state_next = wfba_pkg::S_FIN;
                if (scan_found)
                begin
                    taken_next[scan_pick] = 1'b1;
                    sum_base        = {1'b0, used_reg};
                    sum_add         = sum_base + XW'(size_reg);
                    used_next       = sum_add[XW-1] ? '1 : sum_add[XW-2:0];
                    res_status_next = wfba_pkg::ST_GRANT;
                    res_index_next  = scan_pick;
                    res_left_next   = scan_best - size_reg;
                end
                else
                begin
                    res_status_next = wfba_pkg::ST_NOFIT;
                    res_index_next  = '0;
                    res_left_next   = '0;
                end
            end
            wfba_pkg::S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_index_next  = index_wide[wfba_pkg::INDEX_W-1:0];
                    out_left_next   = wfba_pkg::SIZE_W'(res_left_reg);
                    out_req_next    = req_reg;
                    out_used_next   = used_reg;
                    out_cap_next    = cap_reg;
                    state_next      = wfba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = wfba_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wfba_pkg::S_IDLE;
            count_reg     <= '0;
            req_reg       <= '0;
            used_reg      <= '0;
            cap_reg       <= '0;
            taken_reg     <= '0;
            issue_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            req_reg       <= req_next;
            used_reg      <= used_next;
            cap_reg       <= cap_next;
            taken_reg     <= taken_next;
            issue_reg     <= issue_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        size_reg       <= size_next;
        cmp_idx_reg    <= cmp_idx_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_left_reg   <= res_left_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_left_reg   <= out_left_next;
        out_req_reg    <= out_req_next;
        out_used_reg   <= out_used_next;
        out_cap_reg    <= out_cap_next;
    end

    assign in_stall       = (state_reg != wfba_pkg::S_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign block_index    = out_index_reg;
    assign leftover       = out_left_reg;
    assign request_number = out_req_reg;
    assign used_total     = out_used_reg;
    assign capacity_total = out_cap_reg;

endmodule

// File: rtl/core/wfba_checker.sv
// Port-level checks for the worst-fit block allocator, bound to the top level.
// Depends on wfba_pkg for status codes.
module wfba_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [1:0]                    status,
    input logic [wfba_pkg::INDEX_W-1:0]  block_index,
    input logic [wfba_pkg::SIZE_W-1:0]   leftover,
    input logic [wfba_pkg::SUM_W-1:0]    used_total,
    input logic [wfba_pkg::SUM_W-1:0]    capacity_total
);

    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while previous item still in work");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(leftover))
        else $error("stalled output beat changed");

    a_refusal_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == wfba_pkg::ST_NOFIT || status == wfba_pkg::ST_FULL)
        |-> block_index == '0 && leftover == '0)
        else $error("refused beat carries index or leftover");

    a_used_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> used_total <= capacity_total)
        else $error("used total exceeds capacity total");

endmodule

bind worst_fit_block_allocator_top wfba_checker u_wfba_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .block_index    (block_index),
    .leftover       (leftover),
    .used_total     (used_total),
    .capacity_total (capacity_total)
);

// File: verif/tb_worst_fit_block_allocator_top.sv
// Self-checking bench for worst_fit_block_allocator_top: loads, grants, refusals, clears.
// Depends on wfba_pkg and the block RTL. A ledger class predicts every reply beat
// from the accepted input beats, including the saturating request counter.
module tb_worst_fit_block_allocator_top;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int SLOTS = wfba_pkg::MAX_BLOCKS_DEF;
    localparam logic [20:0] SUM_CEIL = 21'hFFFFF;
    localparam logic [wfba_pkg::REQ_W-1:0] COUNT_CEIL = 16'hFFFF;

    typedef struct packed {
        logic [1:0]                   status;
        logic [wfba_pkg::INDEX_W-1:0] block_index;
        logic [wfba_pkg::SIZE_W-1:0]  leftover;
        logic [wfba_pkg::REQ_W-1:0]   request_number;
        logic [wfba_pkg::SUM_W-1:0]   used_total;
        logic [wfba_pkg::SUM_W-1:0]   capacity_total;
    } alloc_reply_t;

    class allocation_ledger;
        logic [wfba_pkg::SIZE_W-1:0] slot_size [SLOTS];
        bit                          slot_taken [SLOTS];
        int unsigned                 slots_used;
        logic [wfba_pkg::REQ_W-1:0]  requests_seen;
        logic [20:0]                 used_sum;
        logic [20:0]                 capacity_sum;
        alloc_reply_t                due_replies [$];
        int unsigned                 mismatches;

        function new();
            foreach (slot_taken[j])
            begin
                slot_taken[j] = 1'b0;
                slot_size[j] = '0;
            end
            slots_used = 0;
            requests_seen = '0;
            used_sum = '0;
            capacity_sum = '0;
            mismatches = 0;
        endfunction

        function logic [20:0] add_capped(logic [20:0] a, logic [wfba_pkg::SIZE_W-1:0] b);
            logic [20:0] s;
            s = a + b;
            return (s > SUM_CEIL) ? SUM_CEIL : s;
        endfunction

        function void note_item(logic [1:0] op, logic [wfba_pkg::SIZE_W-1:0] amount);
            alloc_reply_t want;
            bit found;
            logic [wfba_pkg::SIZE_W-1:0] best;
            int pick;
            want = '0;
            want.status = wfba_pkg::ST_DONE;
            found = 1'b0;
            best = '0;
            pick = 0;
            case (op)
                wfba_pkg::OP_LOAD:
                    if (slots_used < SLOTS)
                    begin
                        slot_size[slots_used] = amount;
                        slot_taken[slots_used] = 1'b0;
                        want.block_index = slots_used[wfba_pkg::INDEX_W-1:0];
                        slots_used++;
                        capacity_sum = add_capped(capacity_sum, amount);
                    end
                    else
                    begin
                        want.status = wfba_pkg::ST_FULL;
                    end
                wfba_pkg::OP_REQUEST:
                begin
                    if (requests_seen != COUNT_CEIL)
                        requests_seen++;
                    for (int j = 0; j < slots_used; j++)
                    begin
                        if (!slot_taken[j] && slot_size[j] >= amount
                            && (!found || slot_size[j] >= best))
                        begin
                            found = 1'b1;
                            best = slot_size[j];
                            pick = j;
                        end
                    end
                    if (found)
                    begin
                        slot_taken[pick] = 1'b1;
                        used_sum = add_capped(used_sum, amount);
                        want.status = wfba_pkg::ST_GRANT;
                        want.block_index = pick[wfba_pkg::INDEX_W-1:0];
                        want.leftover = best - amount;
                    end
                    else
                    begin
                        want.status = wfba_pkg::ST_NOFIT;
                    end
                end
                wfba_pkg::OP_CLEAR:
                begin
                    foreach (slot_taken[j])
                        slot_taken[j] = 1'b0;
                    slots_used = 0;
                    used_sum = '0;
                    capacity_sum = '0;
                end
                default:
                    ;
            endcase
            want.request_number = requests_seen;
            want.used_total = used_sum[wfba_pkg::SUM_W-1:0];
            want.capacity_total = capacity_sum[wfba_pkg::SUM_W-1:0];
            due_replies.push_back(want);
        endfunction

        task note_fault(string msg);
            $display("%s", msg);
            mismatches++;
        endtask

        task check_reply(alloc_reply_t got);
            alloc_reply_t want;
            if (due_replies.size() == 0)
            begin
                note_fault($sformatf("reply beat with nothing outstanding: status %0d index %0d",
                                     got.status, got.block_index));
            end
            else
            begin
                want = due_replies.pop_front();
                if (got.status != want.status)
                    note_fault($sformatf("status mismatch: got %0d want %0d",
                                         got.status, want.status));
                if (got.block_index != want.block_index)
                    note_fault($sformatf("block_index mismatch: got %0d want %0d",
                                         got.block_index, want.block_index));
                if (got.leftover != want.leftover)
                    note_fault($sformatf("leftover mismatch: got %0d want %0d",
                                         got.leftover, want.leftover));
                if (got.request_number != want.request_number)
                    note_fault($sformatf("request_number mismatch: got %0d want %0d",
                                         got.request_number, want.request_number));
                if (got.used_total != want.used_total)
                    note_fault($sformatf("used_total mismatch: got %0d want %0d",
                                         got.used_total, want.used_total));
                if (got.capacity_total != want.capacity_total)
                    note_fault($sformatf("capacity_total mismatch: got %0d want %0d",
                                         got.capacity_total, want.capacity_total));
            end
        endtask
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic [1:0]                   operation;
    logic [wfba_pkg::SIZE_W-1:0]  size;
    logic                         out_valid;
    logic                         out_stall;
    logic [1:0]                   status;
    logic [wfba_pkg::INDEX_W-1:0] block_index;
    logic [wfba_pkg::SIZE_W-1:0]  leftover;
    logic [wfba_pkg::REQ_W-1:0]   request_number;
    logic [wfba_pkg::SUM_W-1:0]   used_total;
    logic [wfba_pkg::SUM_W-1:0]   capacity_total;

    allocation_ledger ledger;
    int unsigned      tx_idle_pct;
    int unsigned      rx_idle_pct;
    int unsigned      items_sent;

    worst_fit_block_allocator_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .size           (size),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .block_index    (block_index),
        .leftover       (leftover),
        .request_number (request_number),
        .used_total     (used_total),
        .capacity_total (capacity_total)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                ledger.note_item(operation, size);
            if (out_valid && !out_stall)
                ledger.check_reply(alloc_reply_t'({status, block_index, leftover,
                                                   request_number, used_total,
                                                   capacity_total}));
        end
    end

    function automatic logic [wfba_pkg::SIZE_W-1:0] rand_size();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2, 3: return wfba_pkg::SIZE_W'($urandom_range(1, 64));
            default: return wfba_pkg::SIZE_W'($urandom_range(65535));
        endcase
    endfunction

    task automatic send_item(input logic [1:0] op,
                             input logic [wfba_pkg::SIZE_W-1:0] amount);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        size <= amount;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    task automatic hold_for_replies();
        @(negedge clk);
        in_valid <= 1'b0;
        while (ledger.due_replies.size() != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    task automatic run_sequence();
        logic [wfba_pkg::SIZE_W-1:0] held [$];
        logic [wfba_pkg::SIZE_W-1:0] v;
        int n_loads;
        int n_reqs;
        if ($urandom_range(4) != 0)
            send_item(wfba_pkg::OP_CLEAR, rand_size());
        n_loads = ($urandom_range(7) == 0) ? $urandom_range(SLOTS, SLOTS + 3)
                                           : $urandom_range(1, SLOTS);
        repeat (n_loads)
        begin
            if (held.size() != 0 && $urandom_range(3) == 0)
                v = held[$urandom_range(held.size() - 1)];
            else
                v = rand_size();
            held.push_back(v);
            send_item(wfba_pkg::OP_LOAD, v);
        end
        n_reqs = $urandom_range(1, n_loads + 3);
        repeat (n_reqs)
        begin
            v = held[$urandom_range(held.size() - 1)];
            case ($urandom_range(7))
                0, 1, 2: v = (v > 3) ? v - wfba_pkg::SIZE_W'($urandom_range(3)) : v;
                3: v = v + 1'b1;
                4: v = '0;
                5: v = rand_size();
                default: ;
            endcase
            if ($urandom_range(15) == 0)
                send_item(OP_UNUSED, v);
            else if ($urandom_range(11) == 0)
                send_item(wfba_pkg::OP_LOAD, v);
            else
                send_item(wfba_pkg::OP_REQUEST, v);
        end
    endtask

    task automatic run_random(input int unsigned quota);
        int unsigned mark;
        mark = items_sent;
        while (items_sent - mark < quota)
        begin
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(1, 8)) send_item(2'($urandom_range(3)), rand_size());
            else
                run_sequence();
        end
    endtask

    initial
    begin
        ledger = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = wfba_pkg::OP_LOAD;
        size = '0;
        items_sent = 0;
        tx_idle_pct = 21;
        rx_idle_pct = 76;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        send_item(OP_UNUSED, 16'h1234);
        send_item(wfba_pkg::OP_REQUEST, 16'd0);
        send_item(wfba_pkg::OP_LOAD, 16'hFFFF);
        send_item(wfba_pkg::OP_LOAD, 16'd100);
        send_item(wfba_pkg::OP_LOAD, 16'd100);
        send_item(wfba_pkg::OP_LOAD, 16'd50);
        send_item(wfba_pkg::OP_LOAD, 16'd0);
        send_item(wfba_pkg::OP_REQUEST, 16'd100);
        send_item(wfba_pkg::OP_REQUEST, 16'd0);
        send_item(wfba_pkg::OP_REQUEST, 16'd100);
        send_item(wfba_pkg::OP_REQUEST, 16'd60);
        send_item(wfba_pkg::OP_REQUEST, 16'd0);
        send_item(wfba_pkg::OP_REQUEST, 16'd0);
        send_item(wfba_pkg::OP_REQUEST, 16'd0);
        for (int k = 0; k < 11; k++)
            send_item(wfba_pkg::OP_LOAD, 16'hFFFF - 16'(k));
        send_item(wfba_pkg::OP_LOAD, 16'hFFFF);
        send_item(wfba_pkg::OP_REQUEST, 16'hFFFF);
        send_item(wfba_pkg::OP_CLEAR, 16'hFFFF);
        send_item(OP_UNUSED, 16'h0000);

        run_random(570);
        hold_for_replies();

        tx_idle_pct = 76;
        rx_idle_pct = 21;
        run_random(570);
        hold_for_replies();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(280);
        run_random(280);

        @(negedge clk);
        in_valid <= 1'b0;
        while (ledger.due_replies.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (ledger.mismatches == 0)
            $display("worst_fit_block_allocator_top test passed");
        else
            $display("worst_fit_block_allocator_top test failed");
        $finish;
    end

    initial
    begin
        #30000000;
        $display("worst_fit_block_allocator_top test failed");
        $finish;
    end

endmodule
